FILE: hw/rtl/fbmt_pkg.sv
// fbmt_pkg: shared constants, command and status codes and control types
// for the flash block map table; no dependencies
package fbmt_pkg;

	localparam int FLASH_COUNT      = 8;
	localparam int BLOCKS_PER_FLASH = 1024;
	localparam int PAGES_PER_BLOCK  = 64;
	localparam int PAGE_SECTORS     = 8;
	localparam int TABLE_DEPTH      = FLASH_COUNT * BLOCKS_PER_FLASH;
	localparam int IDX_W            = $clog2(TABLE_DEPTH);

	localparam int CMD_W    = 2;
	localparam int LFLASH_W = 3;
	localparam int LBLOCK_W = 10;
	localparam int FLASH_W  = 4;
	localparam int BLOCK_W  = 10;
	localparam int SECTOR_W = 22;
	localparam int STATUS_W = 2;
	localparam int PAGE_W   = 6;
	localparam int ENTRY_W  = 1 + FLASH_W + BLOCK_W;

	localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_ACCESS,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic access;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_stat_t;

endpackage

FILE: hw/rtl/fbmt_ctrl.sv
// fbmt_ctrl: sequencing state machine for the flash block map table
// depends on fbmt_pkg
module fbmt_ctrl
	import fbmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  dcmd,
	output logic     busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				dcmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					dcmd.load = 1'b1;
					state_d   = S_ACCESS;
				end
			end
			S_ACCESS: begin
				dcmd.access = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				dcmd.finish = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/fbmt_dp.sv
// fbmt_dp: address decode, mapping table memory and result registers
// depends on fbmt_pkg
module fbmt_dp
	import fbmt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             dcmd,
	output dp_stat_t            stat,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [LFLASH_W-1:0] log_flash,
	input  logic [LBLOCK_W-1:0] log_block,
	input  logic [FLASH_W-1:0]  new_flash,
	input  logic [BLOCK_W-1:0]  new_block,
	input  logic [SECTOR_W-1:0] sector,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [FLASH_W-1:0]  out_flash,
	output logic [BLOCK_W-1:0]  out_block,
	output logic [PAGE_W-1:0]   out_page
);

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic [IDX_W-1:0]           clr_cnt_q;
	logic [CMD_W-1:0]           cmd_q;
	logic [IDX_W-1:0]           idx_q;
	logic [PAGE_W-1:0]          page_q;
	logic                       bad_q;
	logic [FLASH_W+BLOCK_W-1:0] entry_q;

	logic [STATUS_W-1:0] status_q;
	logic [FLASH_W-1:0]  flash_q;
	logic [BLOCK_W-1:0]  block_q;
	logic [PAGE_W-1:0]   opage_q;
	logic                done_q;

	logic [SECTOR_W-1:0] lpage, lblk, lflash;
	logic [IDX_W-1:0]    idx_d;
	logic [PAGE_W-1:0]   page_d;
	logic                bad_d;
	logic [FLASH_W-1:0]  nf_clamp;

	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [ENTRY_W-1:0]  wdata;

	logic [FLASH_W-1:0]  rd_flash;
	logic [BLOCK_W-1:0]  rd_block;

	// sector split into page, block and flash, and per-command table index and range check
	always_comb begin
		lpage    = SECTOR_W'(sector / PAGE_SECTORS);
		lblk     = SECTOR_W'(lpage / PAGES_PER_BLOCK);
		lflash   = SECTOR_W'(lblk / BLOCKS_PER_FLASH);
		nf_clamp = (int'(new_flash) > FLASH_COUNT) ? FLASH_W'(FLASH_COUNT) : new_flash;
		idx_d    = '0;
		page_d   = '0;
		bad_d    = 1'b1;
		case (cmd)
			CMD_UPDATE, CMD_LOOKUP: begin
				bad_d = (int'(log_flash) >= FLASH_COUNT) ||
					(int'(log_block) >= BLOCKS_PER_FLASH);
				idx_d = IDX_W'(int'(log_flash) * BLOCKS_PER_FLASH + int'(log_block));
			end
			CMD_TRANSLATE: begin
				bad_d  = int'(lflash) >= FLASH_COUNT;
				idx_d  = IDX_W'(lblk);
				page_d = PAGE_W'(lpage % PAGES_PER_BLOCK);
			end
			default: begin
				bad_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (dcmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign stat.clear_last = (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q   <= cmd;
			idx_q   <= idx_d;
			page_q  <= page_d;
			bad_q   <= bad_d;
			entry_q <= {nf_clamp, new_block};
		end
	end

	// single write port shared by the clearing pass and updates
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {1'b1, entry_q};
		if (dcmd.clear) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (dcmd.access && cmd_q == CMD_UPDATE && !bad_q) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[idx_q];
	end

	assign rd_flash = rd_q[ENTRY_W-1] ? rd_q[FLASH_W+BLOCK_W-1:BLOCK_W] : FLASH_W'(FLASH_COUNT);
	assign rd_block = rd_q[ENTRY_W-1] ? rd_q[BLOCK_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (dcmd.finish) begin
			if (bad_q) begin
				status_q <= ST_RANGE;
				flash_q  <= '0;
				block_q  <= '0;
				opage_q  <= '0;
			end else begin
				case (cmd_q)
					CMD_UPDATE: begin
						status_q <= ST_OK;
						flash_q  <= '0;
						block_q  <= '0;
						opage_q  <= '0;
					end
					CMD_LOOKUP: begin
						status_q <= ST_OK;
						flash_q  <= rd_flash;
						block_q  <= rd_block;
						opage_q  <= '0;
					end
					CMD_TRANSLATE: begin
						flash_q  <= rd_flash;
						block_q  <= rd_block;
						status_q <= (int'(rd_flash) == FLASH_COUNT) ? ST_UNMAPPED : ST_OK;
						opage_q  <= (int'(rd_flash) == FLASH_COUNT) ? '0 : page_q;
					end
					default: begin
						status_q <= ST_RANGE;
						flash_q  <= '0;
						block_q  <= '0;
						opage_q  <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dcmd.finish;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_flash = flash_q;
	assign out_block = block_q;
	assign out_page  = opage_q;

endmodule

FILE: hw/rtl/flash_block_map_table_top.sv
// flash_block_map_table_top: block-level flash translation table, top level
// depends on fbmt_pkg, fbmt_ctrl and fbmt_dp
// a word is taken when start is high and busy is low; each word passes through
// decode, one table access (one write port, one read port) and result forming,
// and its result shows on the result ports for one cycle with done high, the
// cycle in which busy has already dropped again. done cannot be held off.
// after reset the table is swept clear, one entry a cycle, all 8192 entries,
// with busy high; never-written entries read as flash 8 (unmapped), block 0
module flash_block_map_table_top
	import fbmt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [LFLASH_W-1:0] log_flash,
	input  logic [LBLOCK_W-1:0] log_block,
	input  logic [FLASH_W-1:0]  new_flash,
	input  logic [BLOCK_W-1:0]  new_block,
	input  logic [SECTOR_W-1:0] sector,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [FLASH_W-1:0]  out_flash,
	output logic [BLOCK_W-1:0]  out_block,
	output logic [PAGE_W-1:0]   out_page
);

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	fbmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.dcmd   (dcmd),
		.busy   (busy)
	);

	fbmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dcmd      (dcmd),
		.stat      (stat),
		.cmd       (cmd),
		.log_flash (log_flash),
		.log_block (log_block),
		.new_flash (new_flash),
		.new_block (new_block),
		.sector    (sector),
		.done      (done),
		.status    (status),
		.out_flash (out_flash),
		.out_block (out_block),
		.out_page  (out_page)
	);

endmodule
